>>> src/ttod_pkg.sv
// ============================================================================
// ttod_pkg
// Shared types, constants and span arithmetic for the tick time-of-day clock.
// ============================================================================
package ttod_pkg;

    localparam int TICKS_PER_SEC = 128;
    localparam int USEC_PER_SEC  = 1000000;
    localparam int USEC_PER_TICK = USEC_PER_SEC / TICKS_PER_SEC;

    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 200;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_SET     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_REBASE,
        ST_SPAN,
        ST_MUL,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic load_req;
        logic tick_upd;
        logic rebase;
        logic span;
        logic mul;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    typedef struct packed {
        logic [47:0] sec;
        logic [19:0] usec;
    } span_t;

    // add the span of el ticks to a base time
    function automatic span_t add_span(logic [31:0] el, logic [47:0] sec,
                                       logic [19:0] usec);
        logic [31:0] dsec;
        logic [31:0] rem;
        logic [20:0] dusec;
        logic [20:0] u;
        logic [47:0] s;
        span_t       r;
        dsec  = el / TICKS_PER_SEC;
        rem   = el % TICKS_PER_SEC;
        dusec = 21'(rem * USEC_PER_TICK);
        u     = {1'b0, usec} + dusec;
        s     = sec + 48'(dsec);
        if (u >= 21'(USEC_PER_SEC))
        begin
            s = s + 48'd1;
            u = u - 21'(USEC_PER_SEC);
        end
        r.sec  = s;
        r.usec = u[19:0];
        return r;
    endfunction

endpackage

>>> src/ttod_ctrl.sv
// ============================================================================
// ttod_ctrl
// Request sequencer: walks each request through tick, rebase, span,
// multiply and load steps.
// ============================================================================
module ttod_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ttod_pkg::status_t sts,
    output ttod_pkg::cmd_t    cmd
);
    import ttod_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
                if (s_tvalid)
                    state_next = ST_TICK;
            end
            ST_TICK:
            begin
                cmd.tick_upd = 1'b1;
                state_next   = ST_REBASE;
            end
            ST_REBASE:
            begin
                cmd.rebase = 1'b1;
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                cmd.span   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hold until the output register is free
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/ttod_dp.sv
// ============================================================================
// ttod_dp
// Datapath: tick counter, base snapshot, span adders, split uptime
// multiplier and the output register.
// ============================================================================
module ttod_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ttod_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ttod_pkg::M_DATA_W-1:0] m_tdata,
    input  ttod_pkg::cmd_t                cmd,
    output ttod_pkg::status_t             sts
);
    import ttod_pkg::*;

    // request fields
    logic        kind_reg;
    logic [30:0] adv_reg;
    logic        stv_reg;
    logic [47:0] nsec_reg;
    logic [19:0] nusec_reg;
    logic        szv_reg;
    logic [15:0] nzmw_reg;
    logic [15:0] ndst_reg;

    // clock state
    logic [31:0] tick_reg;
    logic [31:0] base_ticks_reg;
    logic [39:0] base_up_sec_reg;
    logic [19:0] base_up_usec_reg;
    logic [47:0] base_utc_sec_reg;
    logic [19:0] base_utc_usec_reg;
    logic [15:0] zone_mw_reg;
    logic [15:0] zone_dst_reg;
    logic        rebase_reg;

    // report pipeline
    logic [47:0] rep_utc_sec_reg;
    logic [19:0] rep_utc_usec_reg;
    logic [39:0] up_sec_reg;
    logic [19:0] up_usec_reg;
    logic [51:0] prod_lo_reg;
    logic [27:0] prod_hi_reg;
    logic        m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [31:0] tick_sum;
    logic [31:0] elapsed;
    span_t       up_span;
    span_t       utc_span;
    logic [62:0] uptime_total;

    assign tick_sum     = tick_reg + {1'b0, adv_reg};
    assign elapsed      = tick_reg - base_ticks_reg;
    assign up_span      = add_span(elapsed, {8'd0, base_up_sec_reg}, base_up_usec_reg);
    assign utc_span     = add_span(elapsed, base_utc_sec_reg, base_utc_usec_reg);
    assign uptime_total = 63'({prod_hi_reg, 32'd0}) + 63'(prod_lo_reg) + 63'(up_usec_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg  <= s_tuser;
            adv_reg   <= s_tdata[30:0];
            stv_reg   <= s_tdata[31];
            nsec_reg  <= s_tdata[79:32];
            nusec_reg <= s_tdata[99:80];
            szv_reg   <= s_tdata[100];
            nzmw_reg  <= s_tdata[116:101];
            ndst_reg  <= s_tdata[132:117];
        end
        else if (cmd.tick_upd && nusec_reg >= 20'(USEC_PER_SEC))
        begin
            // normalize new microseconds
            nsec_reg  <= nsec_reg + 48'd1;
            nusec_reg <= nusec_reg - 20'(USEC_PER_SEC);
        end
        if (cmd.span)
        begin
            rep_utc_sec_reg  <= utc_span.sec;
            rep_utc_usec_reg <= utc_span.usec;
            up_sec_reg       <= up_span.sec[39:0];
            up_usec_reg      <= up_span.usec;
        end
        if (cmd.mul)
        begin
            prod_lo_reg <= 52'(up_sec_reg[31:0]) * 52'(USEC_PER_SEC);
            prod_hi_reg <= 28'(up_sec_reg[39:32]) * 28'(USEC_PER_SEC);
        end
        if (cmd.load_out)
        begin
            m_tdata_reg <= {5'd0, zone_dst_reg, zone_mw_reg, uptime_total,
                            rep_utc_usec_reg, rep_utc_sec_reg, tick_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg          <= '0;
            base_ticks_reg    <= '0;
            base_up_sec_reg   <= '0;
            base_up_usec_reg  <= '0;
            base_utc_sec_reg  <= '0;
            base_utc_usec_reg <= '0;
            zone_mw_reg       <= '0;
            zone_dst_reg      <= '0;
            rebase_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.tick_upd)
            begin
                if (kind_reg == KIND_ADVANCE)
                begin
                    rebase_reg <= 1'b0;
                    if (adv_reg != '0)
                    begin
                        tick_reg   <= tick_sum;
                        rebase_reg <= tick_sum[31] ^ tick_reg[31];
                    end
                end
                else
                begin
                    rebase_reg <= stv_reg;
                    if (szv_reg)
                    begin
                        zone_mw_reg  <= nzmw_reg;
                        zone_dst_reg <= ndst_reg;
                    end
                end
            end
            if (cmd.rebase && rebase_reg)
            begin
                base_up_sec_reg  <= up_span.sec[39:0];
                base_up_usec_reg <= up_span.usec;
                base_ticks_reg   <= tick_reg;
                if (kind_reg == KIND_SET)
                begin
                    base_utc_sec_reg  <= nsec_reg;
                    base_utc_usec_reg <= nusec_reg;
                end
                else
                begin
                    base_utc_sec_reg  <= utc_span.sec;
                    base_utc_usec_reg <= utc_span.usec;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign sts.out_full = m_tvalid_reg & ~m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule

>>> src/tick_time_of_day_clock_unit.sv
// ============================================================================
// tick_time_of_day_clock_unit
// Tick-driven time-of-day clock with uptime, UTC time and timezone report.
// ============================================================================
//  Channel  Side    Handshake           Payload
//  s        slave   s_tvalid/s_tready   s_tdata: advance/set request, s_tuser: kind
//  m        master  m_tvalid/m_tready   m_tdata: ticks, UTC, uptime, zone
//
//  One request at a time: accept, then tick, rebase, span, multiply
//  and load steps of the sequencer; the 40x20 uptime multiply is split
//  into two registered partial products.
//  Reset clears the tick counter, base snapshot, zone and output valid.
//  A result waits in the output register; the next request is accepted
//  meanwhile and holds in its load step until the result is taken.
// ============================================================================
module tick_time_of_day_clock_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // advance_ticks[30:0], set_time_valid[31], new_utc_sec[79:32],
    // new_utc_usec[99:80], set_zone_valid[100], new_zone_minutes_west[116:101],
    // new_zone_dst[132:117], zero pad
    input  logic [ttod_pkg::S_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tick_count[31:0], utc_sec[79:32], utc_usec[99:80], uptime_usec[162:100],
    // zone_minutes_west[178:163], zone_dst[194:179], zero pad
    output logic [ttod_pkg::M_DATA_W-1:0] m_tdata
);
    import ttod_pkg::*;

    cmd_t    cmd;
    status_t sts;

    ttod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttod_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(m_tvalid && !m_tready))
        else $error("result register overwritten before taken");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

>>> dv/ttod_checker.sv
// ============================================================================
// ttod_checker
// Predicts and checks the reports of the tick time-of-day clock.
// Watches both stream channels, keeps its own tick counter, base snapshot
// and zone, computes the report that each accepted request must produce,
// and compares every accepted report field by field in arrival order.
// ============================================================================
module ttod_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ttod_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ttod_pkg::M_DATA_W-1:0] m_tdata,
    output int unsigned                   errors,
    output int unsigned                   pending,
    output int unsigned                   checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ttod_pkg::*;

    typedef struct packed {
        logic [31:0] tick_count;
        logic [47:0] utc_sec;
        logic [19:0] utc_usec;
        logic [62:0] uptime_usec;
        logic [15:0] zone_west;
        logic [15:0] zone_dst;
    } tod_report_t;

    tod_report_t expected_reports[$];

    logic [31:0] ticks_now;
    logic [31:0] anchor_ticks;
    logic [39:0] anchor_up_sec;
    logic [19:0] anchor_up_usec;
    logic [47:0] anchor_utc_sec;
    logic [19:0] anchor_utc_usec;
    logic [15:0] zone_west_r;
    logic [15:0] zone_dst_r;

    int unsigned err_cnt;
    int unsigned shown;
    int unsigned seen;

    function automatic void add_ticks_span(input logic [31:0] elapsed,
                                           input logic [47:0] sec_in,
                                           input logic [19:0] usec_in,
                                           output logic [47:0] sec_out,
                                           output logic [19:0] usec_out);
        logic [47:0] whole;
        logic [20:0] frac;
        whole = sec_in + 48'(elapsed / TICKS_PER_SEC);
        frac  = 21'(usec_in) + 21'((elapsed % TICKS_PER_SEC) * USEC_PER_TICK);
        if (frac >= 21'(USEC_PER_SEC))
        begin
            whole = whole + 48'd1;
            frac  = frac - 21'(USEC_PER_SEC);
        end
        sec_out  = whole;
        usec_out = frac[19:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [31:0] prev;
        logic [31:0] elapsed;
        logic [30:0] adv;
        logic [47:0] s48;
        logic [19:0] u20;
        logic [47:0] nsec;
        logic [20:0] nusec;
        logic [63:0] up_total;
        tod_report_t want;
        tod_report_t got;
        if (!rst_n)
        begin
            ticks_now       = '0;
            anchor_ticks    = '0;
            anchor_up_sec   = '0;
            anchor_up_usec  = '0;
            anchor_utc_sec  = '0;
            anchor_utc_usec = '0;
            zone_west_r     = '0;
            zone_dst_r      = '0;
            expected_reports.delete();
            err_cnt = 0;
            shown   = 0;
            seen    = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = tod_report_t'({m_tdata[15+179:179], m_tdata[15+163:163],
                                     m_tdata[62+100:100], m_tdata[99:80],
                                     m_tdata[79:32], m_tdata[31:0]});
                got.tick_count  = m_tdata[31:0];
                got.utc_sec     = m_tdata[79:32];
                got.utc_usec    = m_tdata[99:80];
                got.uptime_usec = m_tdata[162:100];
                got.zone_west   = m_tdata[178:163];
                got.zone_dst    = m_tdata[194:179];
                seen++;
                if (expected_reports.size() == 0)
                begin
                    err_cnt++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("unexpected report: ticks=%h utc=%0d.%06d up=%0d",
                                 got.tick_count, $signed(got.utc_sec), got.utc_usec,
                                 got.uptime_usec);
                    end
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.tick_count !== want.tick_count || got.utc_sec !== want.utc_sec
                        || got.utc_usec !== want.utc_usec
                        || got.uptime_usec !== want.uptime_usec
                        || got.zone_west !== want.zone_west
                        || got.zone_dst !== want.zone_dst)
                    begin
                        err_cnt++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("report %0d expected: ticks=%h utc=%0d.%06d up=%0d zone=%0d/%0d",
                                     seen, want.tick_count, $signed(want.utc_sec),
                                     want.utc_usec, want.uptime_usec,
                                     $signed(want.zone_west), $signed(want.zone_dst));
                            $display("report %0d actual:   ticks=%h utc=%0d.%06d up=%0d zone=%0d/%0d",
                                     seen, got.tick_count, $signed(got.utc_sec),
                                     got.utc_usec, got.uptime_usec,
                                     $signed(got.zone_west), $signed(got.zone_dst));
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == KIND_ADVANCE)
                begin
                    adv = s_tdata[30:0];
                    if (adv != '0)
                    begin
                        prev      = ticks_now;
                        ticks_now = prev + {1'b0, adv};
                        if (prev[31] != ticks_now[31])
                        begin
                            elapsed = ticks_now - anchor_ticks;
                            add_ticks_span(elapsed, {8'd0, anchor_up_sec}, anchor_up_usec,
                                           s48, u20);
                            anchor_up_sec  = s48[39:0];
                            anchor_up_usec = u20;
                            add_ticks_span(elapsed, anchor_utc_sec, anchor_utc_usec, s48, u20);
                            anchor_utc_sec  = s48;
                            anchor_utc_usec = u20;
                            anchor_ticks    = ticks_now;
                        end
                    end
                end
                else
                begin
                    if (s_tdata[31])
                    begin
                        elapsed = ticks_now - anchor_ticks;
                        add_ticks_span(elapsed, {8'd0, anchor_up_sec}, anchor_up_usec,
                                       s48, u20);
                        anchor_up_sec  = s48[39:0];
                        anchor_up_usec = u20;
                        nsec  = s_tdata[79:32];
                        nusec = {1'b0, s_tdata[99:80]};
                        if (nusec >= 21'(USEC_PER_SEC))
                        begin
                            nusec = nusec - 21'(USEC_PER_SEC);
                            nsec  = nsec + 48'd1;
                        end
                        anchor_utc_sec  = nsec;
                        anchor_utc_usec = nusec[19:0];
                        anchor_ticks    = ticks_now;
                    end
                    if (s_tdata[100])
                    begin
                        zone_west_r = s_tdata[116:101];
                        zone_dst_r  = s_tdata[132:117];
                    end
                end

                elapsed = ticks_now - anchor_ticks;
                want.tick_count = ticks_now;
                add_ticks_span(elapsed, anchor_utc_sec, anchor_utc_usec, s48, u20);
                want.utc_sec  = s48;
                want.utc_usec = u20;
                add_ticks_span(elapsed, {8'd0, anchor_up_sec}, anchor_up_usec, s48, u20);
                up_total = {24'd0, s48[39:0]} * 64'd1000000 + {44'd0, u20};
                want.uptime_usec = up_total[62:0];
                want.zone_west   = zone_west_r;
                want.zone_dst    = zone_dst_r;
                expected_reports.push_back(want);
            end

            errors  <= err_cnt;
            pending <= expected_reports.size();
            checked <= seen;
        end
    end

endmodule

>>> dv/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the tick time-of-day clock unit.
// Sends directed advance and set requests over the extremes, then random
// ones with idle gaps and stalls on both channels, a long receiver hold-off
// and a full drain; the checker module predicts and compares every report.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ttod_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 650;
    localparam int unsigned RX_HOLD_CYCLES  = 200;
    localparam int unsigned IDLE_LIMIT      = 4000;

    typedef struct {
        logic        kind;
        logic [30:0] ticks;
        logic        set_time;
        logic [47:0] utc_sec;
        logic [19:0] utc_usec;
        logic        set_zone;
        logic [15:0] zone_west;
        logic [15:0] zone_dst;
    } tod_request_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int unsigned errors;
    int unsigned pending;
    int unsigned checked;
    int unsigned n_advance;
    int unsigned n_set;
    bit          rx_hold_req;
    bit          rx_free;
    bit          tx_steady;

    tick_time_of_day_clock_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ttod_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 60);
    endfunction

    function automatic int unsigned tx_gap();
        if (tx_steady || $urandom_range(0, 99) < 65)
            return 0;
        return idle_len();
    endfunction

    function automatic tod_request_t mk_advance(input logic [30:0] ticks);
        tod_request_t rq;
        rq.kind      = KIND_ADVANCE;
        rq.ticks     = ticks;
        rq.set_time  = 1'b0;
        rq.utc_sec   = '0;
        rq.utc_usec  = '0;
        rq.set_zone  = 1'b0;
        rq.zone_west = '0;
        rq.zone_dst  = '0;
        return rq;
    endfunction

    function automatic tod_request_t mk_set(input logic set_time, input logic [47:0] sec,
                                            input logic [19:0] usec, input logic set_zone,
                                            input logic [15:0] west, input logic [15:0] dst);
        tod_request_t rq;
        rq.kind      = KIND_SET;
        rq.ticks     = 31'($urandom());
        rq.set_time  = set_time;
        rq.utc_sec   = sec;
        rq.utc_usec  = usec;
        rq.set_zone  = set_zone;
        rq.zone_west = west;
        rq.zone_dst  = dst;
        return rq;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(input tod_request_t rq);
        return S_DATA_W'({rq.zone_dst, rq.zone_west, rq.set_zone, rq.utc_usec,
                          rq.utc_sec, rq.set_time, rq.ticks});
    endfunction

    task automatic send_request(input tod_request_t rq, input int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom()});
            s_tuser  <= 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(rq);
        s_tuser  <= rq.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (rq.kind == KIND_ADVANCE)
            n_advance++;
        else
            n_set++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                rx_hold_req = 1'b0;
                repeat (RX_HOLD_CYCLES)
                    @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (!rx_free && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (idle_len())
                    @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: end the run if nothing moves for too long
    initial
    begin
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no request or report moved for %0d cycles", IDLE_LIMIT);
        $display("tick_time_of_day_clock_unit: mismatch");
        $finish;
    end

    initial
    begin
        tod_request_t rq;
        int unsigned  r;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        rx_hold_req = 1'b0;
        rx_free     = 1'b0;
        tx_steady   = 1'b0;
        n_advance   = 0;
        n_set       = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(mk_advance(31'd0), 0);
        send_request(mk_advance(31'd1), 1);
        send_request(mk_advance(31'd127), 0);
        send_request(mk_advance(31'd128), 2);
        send_request(mk_advance(31'h7FFF_FFFF), 0);
        send_request(mk_advance(31'h7FFF_FFFF), 3);
        send_request(mk_set(1'b0, '1, '1, 1'b0, '1, '1), 0);
        send_request(mk_set(1'b1, 48'h7FFF_FFFF_FFFF, 20'd999999, 1'b0, '0, '0), 0);
        send_request(mk_advance(31'd1), 0);
        send_request(mk_advance(31'd5000), 1);
        send_request(mk_set(1'b1, 48'h8000_0000_0000, 20'hFFFFF, 1'b0, '0, '0), 0);
        send_request(mk_set(1'b1, '1, 20'd1000000, 1'b0, '0, '0), 0);
        send_request(mk_set(1'b0, '0, '0, 1'b1, 16'h8000, 16'h7FFF), 0);
        send_request(mk_set(1'b0, '0, '0, 1'b1, 16'h7FFF, 16'h8000), 2);
        send_request(mk_set(1'b1, 48'd1234567, 20'd999999, 1'b1, 16'hFFFF, 16'h0001), 0);
        rq           = mk_advance(31'd3);
        rq.set_time  = 1'b1;
        rq.utc_sec   = '1;
        rq.utc_usec  = '1;
        rq.set_zone  = 1'b1;
        rq.zone_west = '1;
        rq.zone_dst  = '1;
        send_request(rq, 0);
        rq       = mk_set(1'b0, '0, '0, 1'b1, 16'd300, 16'd1);
        rq.ticks = '1;
        send_request(rq, 0);
        send_request(mk_advance(31'h4000_0000), 0);
        send_request(mk_advance(31'h4000_0000), 0);
        send_request(mk_advance(31'h7FFF_FFFF), 0);
        send_request(mk_advance(31'h7FFF_FFFF), 0);
        send_request(mk_set(1'b1, '0, '0, 1'b0, '0, '0), 0);
        send_request(mk_advance(31'd0), 4);

        for (int unsigned i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 150)
            begin
                rx_hold_req = 1'b1;
                tx_steady   = 1'b1;
            end
            if (i == 175)
                tx_steady = 1'b0;
            if (i == 300)
            begin
                rx_free   = 1'b1;
                tx_steady = 1'b1;
            end
            if (i == 360)
            begin
                rx_free   = 1'b0;
                tx_steady = 1'b0;
            end
            if (i == 450)
                drain();

            rq.kind      = ($urandom_range(0, 99) < 55) ? KIND_ADVANCE : KIND_SET;
            rq.ticks     = 31'($urandom());
            rq.set_time  = 1'($urandom_range(0, 1));
            rq.set_zone  = 1'($urandom_range(0, 1));
            rq.zone_west = 16'($urandom());
            rq.zone_dst  = 16'($urandom());
            case ($urandom_range(0, 9))
                0:       rq.utc_sec = 48'h7FFF_FFFF_FFFF - 48'($urandom_range(0, 3));
                1:       rq.utc_sec = 48'h8000_0000_0000 + 48'($urandom_range(0, 3));
                2:       rq.utc_sec = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
                default: rq.utc_sec = 48'({$urandom(), $urandom()});
            endcase
            if ($urandom_range(0, 9) == 0)
                rq.utc_usec = 20'($urandom_range(999990, 1048575));
            else
                rq.utc_usec = 20'($urandom_range(0, 999999));
            if (rq.kind == KIND_ADVANCE)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    rq.ticks = '0;
                else if (r < 45)
                    rq.ticks = 31'($urandom_range(1, 300));
                else if (r < 65)
                    rq.ticks = 31'($urandom_range(1, 1 << 20));
                else if (r < 85)
                    rq.ticks = 31'($urandom());
                else
                    rq.ticks = 31'h7FFF_FFFF - 31'($urandom_range(0, 4095));
            end
            send_request(rq, tx_gap());
        end

        drain();
        repeat (20)
            @(posedge clk);
        $display("sent %0d advance and %0d set requests, checked %0d reports",
                 n_advance, n_set, checked);
        $display("run included a %0d-cycle receiver hold-off and a full drain",
                 RX_HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("tick_time_of_day_clock_unit: match");
        else
            $display("tick_time_of_day_clock_unit: mismatch");
        $finish;
    end

endmodule
